### design/lps_pkg.sv
package lps_pkg;

    localparam int MAX_PILES  = 256;
    localparam int VALUE_BITS = 16;
    localparam int IDX_BITS   = $clog2(MAX_PILES);
    localparam int CNT_BITS   = $clog2(MAX_PILES + 1);
    localparam int LEN_BITS   = 9;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] value;
        logic                         start_req;
    } lps_item_t;

    typedef struct packed {
        logic [LEN_BITS-1:0] lis_length;
        logic                overflowed;
    } lps_result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LAST,
        ST_DECIDE,
        ST_PROBE,
        ST_DONE
    } lps_state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_LAST,
        OP_DECIDE,
        OP_PROBE,
        OP_LOAD
    } lps_op_t;

    typedef struct packed {
        logic empty;
        logic gt;
        logic search_done;
        logic out_busy;
    } lps_status_t;

endpackage

### design/lps_ctrl.sv
module lps_ctrl
    import lps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  lps_status_t status,
    output lps_op_t     op
);

    lps_state_t state_reg;
    lps_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op         = OP_NONE;
        item_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                item_stall = 1'b0;
                if (item_valid)
                begin
                    op         = OP_ACCEPT;
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                op         = OP_LAST;
                state_next = status.empty ? ST_DONE : ST_DECIDE;
            end
            ST_DECIDE:
            begin
                op         = OP_DECIDE;
                state_next = (status.gt || status.search_done) ? ST_DONE : ST_PROBE;
            end
            ST_PROBE:
            begin
                op         = OP_PROBE;
                state_next = status.search_done ? ST_DONE : ST_PROBE;
            end
            ST_DONE:
            begin
                if (!status.out_busy)
                begin
                    op         = OP_LOAD;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### design/lps_datapath.sv
module lps_datapath
    import lps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  lps_item_t   item,
    input  lps_op_t     op,
    output lps_status_t status,
    output logic        result_valid,
    input  logic        result_stall,
    output lps_result_t result
);

    logic signed [VALUE_BITS-1:0] pile_tops [MAX_PILES];

    logic signed [VALUE_BITS-1:0] value_reg;
    logic signed [VALUE_BITS-1:0] rd_data_reg;
    logic [CNT_BITS-1:0]          count_reg;
    logic [CNT_BITS-1:0]          count_next;
    logic                         ovf_reg;
    logic                         ovf_next;
    logic [IDX_BITS-1:0]          lo_reg;
    logic [IDX_BITS-1:0]          lo_next;
    logic [IDX_BITS-1:0]          hi_reg;
    logic [IDX_BITS-1:0]          hi_next;
    logic [IDX_BITS-1:0]          mid_reg;
    logic [IDX_BITS-1:0]          mid_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    lps_result_t                  out_item_reg;

    logic                wr_en;
    logic [IDX_BITS-1:0] wr_addr;
    logic                rd_en;
    logic [IDX_BITS-1:0] rd_addr;

    logic                gt;
    logic [IDX_BITS-1:0] lo_s;
    logic [IDX_BITS-1:0] hi_s;
    logic [IDX_BITS:0]   mid_sum;
    logic [IDX_BITS-1:0] last_idx;
    logic                search_done;

    assign gt          = value_reg > rd_data_reg;
    assign last_idx    = IDX_BITS'(count_reg - CNT_BITS'(1));
    assign mid_sum     = {1'b0, lo_s} + {1'b0, hi_s};
    assign search_done = !(lo_s < hi_s);

    // Bounds for the next search step: the first step covers the whole table,
    // later ones narrow the range around the previous probe.
    always_comb
    begin
        lo_s = '0;
        hi_s = last_idx;
        if (op == OP_PROBE)
        begin
            if (gt)
            begin
                lo_s = mid_reg + IDX_BITS'(1);
                hi_s = hi_reg;
            end
            else
            begin
                lo_s = lo_reg;
                hi_s = mid_reg;
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        wr_en      = 1'b0;
        wr_addr    = '0;
        rd_en      = 1'b0;
        rd_addr    = '0;
        out_valid_next = out_valid_reg && result_stall;
        case (op)
            OP_ACCEPT:
            begin
                if (item.start_req)
                begin
                    count_next = '0;
                    ovf_next   = 1'b0;
                end
            end
            OP_LAST:
            begin
                if (count_reg == '0)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = '0;
                    count_next = CNT_BITS'(1);
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = last_idx;
                end
            end
            OP_DECIDE, OP_PROBE:
            begin
                if (op == OP_DECIDE && gt)
                begin
                    if (count_reg == CNT_BITS'(MAX_PILES))
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = IDX_BITS'(count_reg);
                        count_next = count_reg + CNT_BITS'(1);
                    end
                end
                else if (search_done)
                begin
                    wr_en   = 1'b1;
                    wr_addr = lo_s;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = mid_sum[IDX_BITS:1];
                    mid_next = mid_sum[IDX_BITS:1];
                    lo_next  = lo_s;
                    hi_next  = hi_s;
                end
            end
            OP_LOAD:
            begin
                out_valid_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pile_tops[wr_addr] <= value_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= pile_tops[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (op == OP_ACCEPT)
        begin
            value_reg <= item.value;
        end
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        mid_reg <= mid_next;
        if (op == OP_LOAD)
        begin
            out_item_reg.lis_length <= LEN_BITS'(count_reg);
            out_item_reg.overflowed <= ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign status.empty       = (count_reg == '0);
    assign status.gt          = gt;
    assign status.search_done = search_done;
    assign status.out_busy    = out_valid_reg && result_stall;

    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

endmodule

### design/lis_patience_sort.sv
// Channel   Direction  Handshake                    Payload
// item      in         item_valid / item_stall      lps_item_t   (value, start_req)
// result    out        result_valid / result_stall  lps_result_t (lis_length, overflowed)
//
// Each item passes through accept, a read of the last top or the write into an empty
// table, a compare, up to eight lower-bound probes, and loading of the result register.
// The probe count follows the single registered read port of the pile table.
// Reset clears the pile count, the overflow flag and the result valid; the table
// itself needs no clearing, as only entries below the count are ever read.
// A stalled result holds the block in its done state until the result is taken.
module lis_patience_sort
    import lps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  lps_item_t   item,
    output logic        result_valid,
    input  logic        result_stall,
    output lps_result_t result
);

    lps_op_t     op;
    lps_status_t status;

    lps_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .status     (status),
        .op         (op)
    );

    lps_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .op           (op),
        .status       (status),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
